// ===== src/cmst_pkg.sv =====
package cmst_pkg;

    localparam int CAR_COUNT  = 21;
    localparam int IDX_W      = 5;
    localparam int ID_W       = 11;
    localparam int EV_W       = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] SEEN_LIMIT = 8'hee;

    // Low nibble address commands.
    localparam logic [3:0] CMD_APPLY   = 4'h1;
    localparam logic [3:0] CMD_ACK     = 4'h2;
    localparam logic [3:0] CMD_RELEASE = 4'h3;

    // High nibble result commands.
    localparam logic [3:0] RES_REPORT = 4'h1;
    localparam logic [3:0] RES_ACK    = 4'h2;

    // Event bit positions.
    localparam int EV_STOP_SEND   = 0;
    localparam int EV_ADDR_FIRST  = 1;
    localparam int EV_RESULT_ACK  = 2;
    localparam int EV_NEW_APPLY   = 3;
    localparam int EV_RESULT_CAPT = 4;

    // Register index of the mode register.
    localparam logic REG_AUTO_MODE = 1'b0;

    typedef logic [CAR_COUNT-1:0] t_mask;
    typedef logic [7:0]           t_seen;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic            is_standard;
        logic [7:0]      byte_zero;
        logic [7:0]      byte_one;
        logic [7:0]      byte_two;
        logic [7:0]      byte_three;
        logic [7:0]      byte_four;
        logic [7:0]      byte_five;
    } t_in_item;

    typedef struct packed {
        logic             node_valid;
        logic [IDX_W-1:0] node_index;
        logic [EV_W-1:0]  events;
        t_mask            application_mask;
        t_mask            received_mask;
        t_mask            deliver_mask;
        t_mask            alive_mask;
        logic [7:0]       fault_code;
        logic [15:0]      result_number;
        logic [15:0]      pocket_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } t_payload;

    typedef struct packed {
        logic fire;
        logic auto_mode;
    } t_trk_ctrl;

    // Saturating first-seen counter step.
    function automatic t_seen f_bump(input t_seen ctr);
        t_seen res;
        if (ctr >= SEEN_LIMIT - 8'd1) begin
            res = SEEN_LIMIT;
        end else begin
            res = ctr + 8'd1;
        end
        return res;
    endfunction

endpackage

// ===== src/cmst_cfg.sv =====
module cmst_cfg
    import cmst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_auto_mode
);

    logic r_auto_mode;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_AUTO_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode <= 1'b1;
        end else if (wr_en) begin
            r_auto_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_AUTO_MODE)
                    ? {{(APB_DATA_W-1){1'b0}}, r_auto_mode} : '0;
    assign o_auto_mode = r_auto_mode;

endmodule

// ===== src/cmst_tracker.sv =====
module cmst_tracker
    import cmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_trk_ctrl i_ctrl,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    t_payload         r_last;
    t_seen            r_apply_seen  [CAR_COUNT];
    t_seen            r_ack_seen    [CAR_COUNT];
    t_seen            r_report_seen [CAR_COUNT];
    t_mask            r_apply_bits;
    t_mask            r_recv_bits;
    t_mask            r_report_bits;
    t_mask            r_heard_bits;

    t_payload         n_last;
    t_seen            n_apply_seen  [CAR_COUNT];
    t_seen            n_ack_seen    [CAR_COUNT];
    t_seen            n_report_seen [CAR_COUNT];
    t_mask            n_apply_bits;
    t_mask            n_recv_bits;
    t_mask            n_report_bits;
    t_mask            n_heard_bits;

    logic             hit;
    logic [IDX_W-1:0] idx;
    t_mask            sel;
    logic [3:0]       lo;
    logic [3:0]       hi;
    logic [EV_W-1:0]  events;
    logic             captured;

    always_comb begin
        // An extended frame works on the payload held from the last standard frame.
        n_last = i_item.is_standard
                 ? {i_item.byte_zero, i_item.byte_one, i_item.byte_two,
                    i_item.byte_three, i_item.byte_four, i_item.byte_five}
                 : r_last;

        hit = (i_item.node_id != '0) && (i_item.node_id <= ID_W'(CAR_COUNT));
        idx = IDX_W'(i_item.node_id - ID_W'(1));
        sel = hit ? (t_mask'(1) << idx) : '0;
        lo  = n_last.b0[3:0];
        hi  = n_last.b0[7:4];

        n_apply_seen  = r_apply_seen;
        n_ack_seen    = r_ack_seen;
        n_report_seen = r_report_seen;
        n_apply_bits  = r_apply_bits;
        n_recv_bits   = r_recv_bits;
        n_report_bits = r_report_bits;
        n_heard_bits  = r_heard_bits | sel;
        events        = '0;
        captured      = 1'b0;

        if (hit) begin
            if (!i_ctrl.auto_mode) begin
                if (lo == CMD_APPLY) begin
                    n_apply_seen[idx] = f_bump(r_apply_seen[idx]);
                    if (r_apply_seen[idx] == '0) begin
                        events[EV_NEW_APPLY] = 1'b1;
                        n_apply_bits = r_apply_bits | sel;
                    end
                    n_ack_seen[idx] = '0;
                end else if (lo == CMD_ACK) begin
                    events[EV_STOP_SEND] = 1'b1;
                    n_ack_seen[idx] = f_bump(r_ack_seen[idx]);
                    if (r_ack_seen[idx] == '0) begin
                        events[EV_ADDR_FIRST] = 1'b1;
                        n_apply_bits = r_apply_bits & ~sel;
                    end
                    n_apply_seen[idx] = '0;
                end
            end else begin
                if (lo == CMD_ACK) begin
                    events[EV_STOP_SEND] = 1'b1;
                    n_ack_seen[idx] = f_bump(r_ack_seen[idx]);
                    if (r_ack_seen[idx] == '0) begin
                        events[EV_ADDR_FIRST] = 1'b1;
                        n_recv_bits = r_recv_bits | sel;
                    end
                end else if (lo == CMD_RELEASE) begin
                    n_ack_seen[idx] = '0;
                    n_recv_bits = r_recv_bits & ~sel;
                end
            end

            if (hi == RES_REPORT) begin
                n_report_seen[idx] = f_bump(r_report_seen[idx]);
                if (r_report_seen[idx] == '0) begin
                    events[EV_RESULT_CAPT] = 1'b1;
                    captured = 1'b1;
                    n_report_bits = r_report_bits | sel;
                end
            end else if (hi == RES_ACK) begin
                events[EV_RESULT_ACK] = 1'b1;
                n_report_bits = r_report_bits & ~sel;
                n_report_seen[idx] = '0;
            end
        end

        o_result.node_valid       = hit;
        o_result.node_index       = hit ? idx : '0;
        o_result.events           = events;
        o_result.application_mask = n_apply_bits;
        o_result.received_mask    = n_recv_bits;
        o_result.deliver_mask     = n_report_bits;
        o_result.alive_mask       = n_heard_bits;
        o_result.fault_code       = hit ? n_last.b3 : '0;
        o_result.result_number    = captured ? {n_last.b1, n_last.b2} : '0;
        o_result.pocket_count     = captured ? {n_last.b4, n_last.b5} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= '0;
            r_apply_seen  <= '{default: '0};
            r_ack_seen    <= '{default: '0};
            r_report_seen <= '{default: '0};
            r_apply_bits  <= '0;
            r_recv_bits   <= '0;
            r_report_bits <= '0;
            r_heard_bits  <= '0;
        end else if (i_ctrl.fire) begin
            r_last        <= n_last;
            r_apply_seen  <= n_apply_seen;
            r_ack_seen    <= n_ack_seen;
            r_report_seen <= n_report_seen;
            r_apply_bits  <= n_apply_bits;
            r_recv_bits   <= n_recv_bits;
            r_report_bits <= n_report_bits;
            r_heard_bits  <= n_heard_bits;
        end
    end

endmodule

// ===== src/car_message_status_tracker.sv =====
// Car message status tracker.
// The input channel (i_in_valid, i_in_item, o_in_stall) takes one received
// bus message per item; the output channel (o_out_valid, o_out_item,
// i_out_stall) returns exactly one result item per message, in order.
// An item is moved on at a clock edge where valid is high and stall is low.
// The mode register sits on the APB port at byte address 0. The user must
// ensure it is written only while the block is idle; this is not enforced.
// An accepted item lands in the input register; when the output side
// advances, the per-car update is committed and its result is loaded
// into the output register. One item is accepted per cycle when the output
// side does not stall; the rate is set by the single read-modify-write of the
// per-car state between the two registers.
// When the receiver stalls, the result stays in the output register and one
// further item is held in the input register; only then is o_in_stall raised.
// Reset clears both valid flags, all per-car counters and masks and the held
// payload, and sets the mode register to automatic scan handling.
module car_message_status_tracker
    import cmst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      advance;
    logic      in_accept;
    logic      auto_mode;
    t_trk_ctrl trk_ctrl;
    t_out_item result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign trk_ctrl.fire      = r_in_valid && advance;
    assign trk_ctrl.auto_mode = auto_mode;

    cmst_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_auto_mode (auto_mode)
    );

    cmst_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (trk_ctrl),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
        if (trk_ctrl.fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A stalled input channel means the output side is holding a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.node_valid)
            |-> (o_out_item.events == '0 && o_out_item.fault_code == '0))
        else $error("events or fault reported for an unknown identifier");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.events[EV_RESULT_CAPT])
            |-> (o_out_item.result_number == '0 && o_out_item.pocket_count == '0))
        else $error("captured values shown without a capture event");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.node_valid)
            |-> (((o_out_item.alive_mask >> o_out_item.node_index) & t_mask'(1)) != '0))
        else $error("alive bit missing for the addressed car");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.events[EV_ADDR_FIRST])
            |-> o_out_item.events[EV_STOP_SEND])
        else $error("first address acknowledge without stop send");

endmodule
